@@ design/assert_macros.svh @@
// Assertion macros shared by the translator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

@@ design/dlrct_pkg.sv @@
package dlrct_pkg;

  localparam int SEGMENT_COUNT = 16;

  // Display-list opcodes
  localparam logic [7:0] OP_TEXTURE      = 8'hD7;
  localparam logic [7:0] OP_MOVEWORD     = 8'hDB;
  localparam logic [7:0] OP_RDPHALF1     = 8'hE1;
  localparam logic [7:0] OP_SETOM_LOW    = 8'hE2;
  localparam logic [7:0] OP_SETOM_HIGH   = 8'hE3;
  localparam logic [7:0] OP_TEXRECT      = 8'hE4;
  localparam logic [7:0] OP_TEXRECT_FLIP = 8'hE5;
  localparam logic [7:0] OP_OTHERMODE    = 8'hEF;
  localparam logic [7:0] OP_RDPHALF2     = 8'hF1;
  localparam logic [7:0] OP_DL_NOP_A     = 8'hD8;
  localparam logic [7:0] OP_DL_NOP_B     = 8'hD9;
  localparam logic [7:0] OP_DL_NOP_C     = 8'hDA;
  localparam logic [7:0] OP_DL_NOP_D     = 8'hDC;
  localparam logic [7:0] OP_DL_NOP_E     = 8'hDD;
  localparam logic [7:0] OP_DL_NOP_F     = 8'hDE;
  localparam logic [7:0] OP_DL_NOP_G     = 8'hDF;
  localparam logic [7:0] RDP_FIRST_OP    = 8'hC8;

  // Moveword index that loads a segment base
  localparam logic [7:0] MW_SEGMENT = 8'h06;

  // RDP command ids
  localparam logic [5:0] ID_FIRST       = 6'h24;
  localparam logic [5:0] ID_SYNC_TILE   = 6'h29;
  localparam logic [5:0] ID_SYNC_CMD    = 6'h31;
  localparam logic [5:0] ID_IMAGE_FIRST = 6'h3D;

  localparam logic [31:0] MODE_HIGH_CMD = 32'h2F000000;
  localparam logic [31:0] ADDR_MASK     = 32'h00FFFFFF;

  // Texture rectangle assembly states
  localparam logic [1:0] RECT_IDLE  = 2'd0;
  localparam logic [1:0] RECT_HALF1 = 2'd1;
  localparam logic [1:0] RECT_HALF2 = 2'd2;

  typedef struct packed {
    logic [31:0] first_word;
    logic [31:0] second_word;
  } cmd_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        depth_enabled;
    logic        texture_on;
  } rdp_t;

endpackage

@@ design/dlrct_ram.sv @@
module dlrct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable; register read data, hold it between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/display_list_rdp_command_translator_unit.sv @@
// Channel | Dir | Handshake             | Payload
// cmd     | in  | cmd_valid / cmd_ready | dlrct_pkg::cmd_t (first_word, second_word)
// rdp     | out | rdp_valid / rdp_ready | dlrct_pkg::rdp_t (word, last, flags)
//
// A command is decoded in its accept cycle; mode, flags and segment writes commit then.
// Words leave one per cycle from the output stage while rdp_ready holds: two per command,
// four per rectangle; the next command can be accepted as the last word is taken.
// The segment table RAM is read at accept; its data is added to the image address word.
// Wordless commands skip the output stage; reset clears control and valid bits at once.
// A stalled output holds the output stage and blocks the next command of any kind.
`include "assert_macros.svh"

module display_list_rdp_command_translator_unit #(
  parameter int SEGMENT_COUNT = dlrct_pkg::SEGMENT_COUNT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  dlrct_pkg::cmd_t cmd,
  output logic            rdp_valid,
  input  logic            rdp_ready,
  output dlrct_pkg::rdp_t rdp
);

  localparam int SEG_W = $clog2(SEGMENT_COUNT);

  // Architectural state
  logic [31:0]              mode_high, mode_high_next;
  logic [31:0]              mode_low, mode_low_next;
  logic                     depth_flag, depth_flag_next;
  logic                     texture_flag, texture_flag_next;
  logic [1:0]               rect_pending, rect_pending_next;
  logic [31:0]              rect_w [4];
  logic [31:0]              rect_w_next [4];
  logic [SEGMENT_COUNT-1:0] seg_valid;

  // Output stage
  logic        full;
  logic [1:0]  idx;
  logic        quad;
  logic        resolve;
  logic        seg_ok;
  logic        depth_out;
  logic        tex_out;
  logic [31:0] wrd [4];

  // Decode signals
  logic             acc;
  logic             take;
  logic             done;
  logic [7:0]       op;
  logic [5:0]       id;
  logic [8:0]       len;
  logic signed [10:0] sh;
  logic [4:0]       sh_c;
  logic [31:0]      mask;
  logic             ld;
  logic             ld_quad;
  logic             ld_resolve;
  logic [31:0]      ld_w [4];
  logic             seg_we;
  logic [SEG_W-1:0] seg_waddr;
  logic [SEG_W-1:0] seg_raddr;
  logic [31:0]      seg_rdata;
  logic [31:0]      seg_base;
  logic [31:0]      out_word;
  logic             out_last;

  assign acc       = cmd_valid && cmd_ready;
  assign take      = rdp_valid && rdp_ready;
  assign done      = take && out_last;
  assign cmd_ready = !full || done;

  assign seg_waddr = cmd.first_word[2 +: SEG_W];
  assign seg_raddr = cmd.second_word[24 +: SEG_W];

  dlrct_ram #(
    .WIDTH (32),
    .DEPTH (SEGMENT_COUNT)
  ) u_seg_ram (
    .clk   (clk),
    .we    (seg_we),
    .waddr (seg_waddr),
    .wdata (cmd.second_word),
    .re    (acc),
    .raddr (seg_raddr),
    .rdata (seg_rdata)
  );

  // Build the other-mode bitfield mask, clamp a negative shift to zero
  always_comb begin
    len  = {1'b0, cmd.first_word[7:0]} + 9'd1;
    sh   = 11'sd32 - $signed({3'b000, cmd.first_word[15:8]}) - $signed({2'b00, len});
    sh_c = sh[10] ? 5'd0 : sh[4:0];
    if (len >= 9'd32) begin
      mask = '1;
    end else begin
      mask = (~(32'hFFFFFFFF << len[4:0])) << sh_c;
    end
  end

  // Decode the command and form next state and output-stage load
  always_comb begin
    op                = cmd.first_word[31:24];
    id                = op[5:0];
    mode_high_next    = mode_high;
    mode_low_next     = mode_low;
    depth_flag_next   = depth_flag;
    texture_flag_next = texture_flag;
    rect_pending_next = dlrct_pkg::RECT_IDLE;
    for (int i = 0; i < 4; i++) begin
      rect_w_next[i] = rect_w[i];
      ld_w[i]        = cmd.first_word;
    end
    ld_w[1]    = cmd.second_word;
    ld         = 1'b0;
    ld_quad    = 1'b0;
    ld_resolve = 1'b0;
    seg_we     = 1'b0;

    if (rect_pending == dlrct_pkg::RECT_HALF1 || rect_pending == dlrct_pkg::RECT_HALF2) begin
      if (op == dlrct_pkg::OP_RDPHALF1) begin
        rect_w_next[2] = cmd.second_word;
      end else if (op == dlrct_pkg::OP_RDPHALF2) begin
        rect_w_next[3] = cmd.second_word;
      end
      if (rect_pending == dlrct_pkg::RECT_HALF1) begin
        rect_pending_next = dlrct_pkg::RECT_HALF2;
      end else begin
        ld      = 1'b1;
        ld_quad = 1'b1;
        for (int i = 0; i < 4; i++) begin
          ld_w[i] = rect_w_next[i];
        end
      end
    end else begin
      case (op)
        dlrct_pkg::OP_TEXTURE: begin
          texture_flag_next = |cmd.first_word[7:1];
        end
        dlrct_pkg::OP_MOVEWORD: begin
          seg_we = acc && (cmd.first_word[23:16] == dlrct_pkg::MW_SEGMENT);
        end
        dlrct_pkg::OP_SETOM_LOW, dlrct_pkg::OP_SETOM_HIGH: begin
          if (op == dlrct_pkg::OP_SETOM_HIGH) begin
            mode_high_next = (mode_high & ~mask) | (cmd.second_word & mask)
                             | dlrct_pkg::MODE_HIGH_CMD;
          end else begin
            mode_low_next = (mode_low & ~mask) | (cmd.second_word & mask);
          end
          depth_flag_next = |mode_low_next[5:4];
          ld      = 1'b1;
          ld_w[0] = mode_high_next | dlrct_pkg::MODE_HIGH_CMD;
          ld_w[1] = mode_low_next;
        end
        dlrct_pkg::OP_OTHERMODE: begin
          mode_high_next  = cmd.first_word;
          mode_low_next   = cmd.second_word;
          depth_flag_next = |cmd.second_word[5:4];
          ld              = 1'b1;
        end
        dlrct_pkg::OP_TEXRECT, dlrct_pkg::OP_TEXRECT_FLIP: begin
          rect_w_next[0]    = cmd.first_word;
          rect_w_next[1]    = cmd.second_word;
          rect_w_next[2]    = '0;
          rect_w_next[3]    = '0;
          rect_pending_next = dlrct_pkg::RECT_HALF1;
        end
        dlrct_pkg::OP_DL_NOP_A, dlrct_pkg::OP_DL_NOP_B, dlrct_pkg::OP_DL_NOP_C,
        dlrct_pkg::OP_DL_NOP_D, dlrct_pkg::OP_DL_NOP_E, dlrct_pkg::OP_DL_NOP_F,
        dlrct_pkg::OP_DL_NOP_G, dlrct_pkg::OP_RDPHALF1: begin
          ld = 1'b0;
        end
        default: begin
          // Forward RDP commands, drop the two syncs, resolve image addresses
          if (op >= dlrct_pkg::RDP_FIRST_OP && id >= dlrct_pkg::ID_FIRST &&
              id != dlrct_pkg::ID_SYNC_TILE && id != dlrct_pkg::ID_SYNC_CMD) begin
            ld         = 1'b1;
            ld_resolve = (id >= dlrct_pkg::ID_IMAGE_FIRST);
          end
        end
      endcase
    end
  end

  // Commit state on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_high    <= dlrct_pkg::MODE_HIGH_CMD;
      mode_low     <= '0;
      depth_flag   <= 1'b0;
      texture_flag <= 1'b0;
      rect_pending <= dlrct_pkg::RECT_IDLE;
      seg_valid    <= '0;
      for (int i = 0; i < 4; i++) begin
        rect_w[i] <= '0;
      end
    end else if (acc) begin
      mode_high    <= mode_high_next;
      mode_low     <= mode_low_next;
      depth_flag   <= depth_flag_next;
      texture_flag <= texture_flag_next;
      rect_pending <= rect_pending_next;
      for (int i = 0; i < 4; i++) begin
        rect_w[i] <= rect_w_next[i];
      end
      if (seg_we) begin
        seg_valid[seg_waddr] <= 1'b1;
      end
    end
  end

  // Advance the output stage one word per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= '0;
    end else begin
      if (done) begin
        full <= 1'b0;
        idx  <= '0;
      end else if (take) begin
        idx <= idx + 2'd1;
      end
      if (acc && ld) begin
        full <= 1'b1;
        idx  <= '0;
      end
    end
  end

  // Load the output payload
  always_ff @(posedge clk) begin
    if (acc && ld) begin
      quad      <= ld_quad;
      resolve   <= ld_resolve;
      seg_ok    <= seg_valid[seg_raddr];
      depth_out <= depth_flag_next;
      tex_out   <= texture_flag_next;
      for (int i = 0; i < 4; i++) begin
        wrd[i] <= ld_w[i];
      end
    end
  end

  // Select the current word; an unwritten segment reads as zero
  always_comb begin
    seg_base = seg_ok ? seg_rdata : '0;
    case (idx)
      2'd0:    out_word = wrd[0];
      2'd1:    out_word = resolve ? seg_base + (wrd[1] & dlrct_pkg::ADDR_MASK) : wrd[1];
      2'd2:    out_word = wrd[2];
      default: out_word = wrd[3];
    endcase
    out_last = quad ? (idx == 2'd3) : (idx == 2'd1);
  end

  assign rdp_valid         = full;
  assign rdp.word          = out_word;
  assign rdp.last          = out_last;
  assign rdp.depth_enabled = depth_out;
  assign rdp.texture_on    = tex_out;

  `ASSERT_NEVER(a_rect_code, clk, rst, rect_pending == 2'd3, "invalid rectangle state")
  `ASSERT_PROP(a_seg_valid, clk, rst, seg_we |=> seg_valid[$past(seg_waddr)], "segment not marked")
  `ASSERT_PROP(a_pair_idx, clk, rst, (full && !quad) |-> (idx <= 2'd1), "pair index overrun")
  `ASSERT_PROP(a_drop_end, clk, rst, $fell(rdp_valid) |-> $past(rdp_ready && out_last), "run cut short")

endmodule
